[rtl/assert_macros.svh]
// Assertion macros shared by the slot table RTL.
// Depends on nothing; the including module supplies clk and rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define CHK_IMPLIES(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");
// Next-cycle implication, disabled while in reset.
`define CHK_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");
`else
`define CHK_IMPLIES(lbl, a, b)
`define CHK_NEXT(lbl, a, b)
`endif
`endif

[rtl/gcst_pkg.sv]
// Package for the generation-checked slot table: sizes, codes, request and
// result types, sequencer states. Depends on nothing.
package gcst_pkg;

  localparam int SLOTS_PER_PAGE = 32;
  localparam int PAGES          = 32;
  localparam int PAYLOAD_W      = 32;
  localparam int TOTAL_SLOTS    = PAGES * SLOTS_PER_PAGE;

  localparam int SLOT_BITS = $clog2(SLOTS_PER_PAGE);
  localparam int PAGE_BITS = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int ADDR_W    = $clog2(TOTAL_SLOTS);

  // Fixed field widths of the request and result.
  localparam int INDEX_W   = 10;
  localparam int STAMP_W   = 64;
  localparam int FIELD_PAY_W = 32;

  // Shared first-set encoder spans the wider of the two searches.
  localparam int FFS_W     = (PAGES > SLOTS_PER_PAGE) ? PAGES : SLOTS_PER_PAGE;
  localparam int FFS_IDX_W = $clog2(FFS_W);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_QUERY  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_FREE = 2'd2
  } status_t;

  typedef struct packed {
    action_t                action;
    logic [FIELD_PAY_W-1:0] payload;
    logic [INDEX_W-1:0]     handle_index;
    logic [STAMP_W-1:0]     handle_stamp;
  } req_t;

  typedef struct packed {
    logic [INDEX_W-1:0]     result_index;
    logic [STAMP_W-1:0]     result_stamp;
    logic [FIELD_PAY_W-1:0] result_payload;
    logic                   found;
    status_t                status;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAGE,
    ST_SLOT,
    ST_REMOVE,
    ST_QREAD,
    ST_QCHECK,
    ST_CLEAR
  } state_t;

endpackage

[rtl/generation_checked_slot_table.sv]
// Channel   Signals            Transfer
// request   start, busy, req   start high and busy low at a rising edge
// result    done, res          done high for one cycle, always taken
//
// Add runs a page search, then a slot search on the shared encoder, and
// stops after the page search when every page is full. Remove and clear
// are one step each; query reads the payload and stamp RAMs, then compares
// stamps. Result appears the cycle after the last step, busy already low.
// The receiver cannot stall the result, so the block never waits on it.
// Reset clears occupancy, the page-full mask and sets the stamp counter to 1.
// Depends on gcst_pkg, gcst_ffs, gcst_ram and assert_macros.svh.
`include "assert_macros.svh"
module generation_checked_slot_table
  import gcst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  req_t req,
  output logic busy,
  output logic done,
  output res_t res
);

  state_t state, state_next;

  logic [SLOTS_PER_PAGE-1:0] occupancy [PAGES];
  logic [PAGES-1:0]          full_pages;
  logic [STAMP_W-1:0]        stamp_counter;

  // Latched request.
  logic [PAGE_BITS-1:0]   page_r;
  logic [INDEX_W-1:0]     idx_r;
  logic                   in_range_r;
  logic [PAYLOAD_W-1:0]   payload_r;
  logic [STAMP_W-1:0]     stamp_r;

  logic [SLOTS_PER_PAGE-1:0] occ_word;
  logic [SLOT_BITS-1:0]      slot_r;
  logic                      bit_hit;

  logic [FFS_W-1:0]     enc_vec;
  logic                 enc_hit;
  logic [FFS_IDX_W-1:0] enc_pos;
  logic [SLOT_BITS-1:0] new_slot;
  logic [SLOTS_PER_PAGE-1:0] set_word;
  logic [STAMP_W-1:0]   stamp_inc;

  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_addr;
  logic [PAYLOAD_W-1:0] pay_rdata;
  logic [STAMP_W-1:0]   stamp_rdata;

  res_t res_next;
  logic done_next;
  logic accept;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Occupancy of the page under work, and the addressed slot.
  assign occ_word = occupancy[page_r];
  assign slot_r   = idx_r[SLOT_BITS-1:0];
  assign bit_hit  = in_range_r && occ_word[slot_r];

  // Feed the shared encoder: free pages, then free slots of the chosen page.
  always_comb begin
    enc_vec = '0;
    if (state == ST_PAGE) begin
      enc_vec[PAGES-1:0] = ~full_pages;
    end else begin
      enc_vec[SLOTS_PER_PAGE-1:0] = ~occ_word;
    end
  end

  gcst_ffs u_ffs (
    .vec (enc_vec),
    .hit (enc_hit),
    .pos (enc_pos)
  );

  assign new_slot  = enc_pos[SLOT_BITS-1:0];
  assign set_word  = occ_word | (SLOTS_PER_PAGE'(1) << new_slot);
  assign stamp_inc = stamp_counter + STAMP_W'(1);

  // RAM port: write on add, otherwise read at the requested index.
  assign ram_we   = (state == ST_SLOT);
  assign ram_addr = (state == ST_SLOT) ? ADDR_W'({page_r, new_slot}) : ADDR_W'(idx_r);

  gcst_ram #(.WIDTH(PAYLOAD_W), .DEPTH(TOTAL_SLOTS)) u_pay_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (payload_r),
    .rdata (pay_rdata)
  );

  gcst_ram #(.WIDTH(STAMP_W), .DEPTH(TOTAL_SLOTS)) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (stamp_inc),
    .rdata (stamp_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (req.action)
            ACT_ADD:    state_next = ST_PAGE;
            ACT_REMOVE: state_next = ST_REMOVE;
            ACT_QUERY:  state_next = ST_QREAD;
            ACT_CLEAR:  state_next = ST_CLEAR;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_PAGE:   state_next = enc_hit ? ST_SLOT : ST_IDLE;
      ST_QREAD:  state_next = ST_QCHECK;
      ST_SLOT, ST_REMOVE, ST_QCHECK, ST_CLEAR: state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Result of the finishing step.
  always_comb begin
    res_next  = '0;
    done_next = 1'b0;
    unique case (state)
      ST_PAGE: begin
        if (!enc_hit) begin
          res_next.status = STS_FULL;
          done_next       = 1'b1;
        end
      end
      ST_SLOT: begin
        res_next.result_index = INDEX_W'({page_r, new_slot});
        res_next.result_stamp = stamp_inc;
        done_next             = 1'b1;
      end
      ST_REMOVE: begin
        if (!bit_hit) begin
          res_next.status = STS_FREE;
        end
        done_next = 1'b1;
      end
      ST_QCHECK: begin
        if (bit_hit && (stamp_rdata == stamp_r)) begin
          res_next.result_payload = FIELD_PAY_W'(pay_rdata);
          res_next.found          = 1'b1;
        end
        done_next = 1'b1;
      end
      ST_CLEAR: begin
        done_next = 1'b1;
      end
      default: begin
        done_next = 1'b0;
      end
    endcase
  end

  // Sequencer, strobe and table state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      done          <= 1'b0;
      full_pages    <= '0;
      stamp_counter <= STAMP_W'(1);
      for (int p = 0; p < PAGES; p++) begin
        occupancy[p] <= '0;
      end
    end else begin
      state <= state_next;
      done  <= done_next;
      unique case (state)
        ST_SLOT: begin
          occupancy[page_r]  <= set_word;
          full_pages[page_r] <= &set_word;
          stamp_counter      <= stamp_inc;
        end
        ST_REMOVE: begin
          if (bit_hit) begin
            occupancy[page_r][slot_r] <= 1'b0;
            full_pages[page_r]        <= 1'b0;
          end
        end
        ST_CLEAR: begin
          full_pages <= '0;
          for (int p = 0; p < PAGES; p++) begin
            occupancy[p] <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Latch the request and the page chosen by the page search.
  always_ff @(posedge clk) begin
    if (accept) begin
      page_r     <= PAGE_BITS'(req.handle_index >> SLOT_BITS);
      idx_r      <= req.handle_index;
      in_range_r <= ({1'b0, req.handle_index} < (INDEX_W + 1)'(TOTAL_SLOTS));
      payload_r  <= PAYLOAD_W'(req.payload);
      stamp_r    <= req.handle_stamp;
    end else if (state == ST_PAGE) begin
      page_r <= enc_pos[PAGE_BITS-1:0];
    end
  end

  // Hold the result between strobes.
  always_ff @(posedge clk) begin
    if (done_next) begin
      res <= res_next;
    end
  end

  `CHK_IMPLIES(a_done_idle, done, !busy)
  `CHK_NEXT(a_accept_busy, accept, busy)
  `CHK_IMPLIES(a_slot_free, state == ST_SLOT, enc_hit)
  `CHK_IMPLIES(a_full_zero, done && (res.status == STS_FULL),
               (res.result_stamp == '0) && (res.result_index == '0))

endmodule

[rtl/gcst_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
module gcst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable; read returns the old contents in the following cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/gcst_ffs.sv]
// Shared lowest-set-bit encoder used for both the page and the slot search.
// Depends on gcst_pkg.
module gcst_ffs
  import gcst_pkg::*;
(
  input  logic [FFS_W-1:0]     vec,
  output logic                 hit,
  output logic [FFS_IDX_W-1:0] pos
);

  // Scan from the top so the lowest set bit wins.
  always_comb begin
    pos = '0;
    for (int i = FFS_W - 1; i >= 0; i--) begin
      if (vec[i]) begin
        pos = FFS_IDX_W'(i);
      end
    end
    hit = |vec;
  end

endmodule
